>>> rtl/core/lfofr_pkg.sv
`default_nettype none

package lfofr_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int CALC_W     = 40;
   localparam int NUM_W      = 48;
   localparam int CHUNK_W    = 8;
   localparam int CDIV_CH    = 5;
   localparam int CDIV_STEPS = NUM_W / CHUNK_W;
   localparam int DIV_STEPS  = FRAC_W + 1;
   localparam int PHI_W      = FRAC_W + 2;
   localparam int BIAS_SH    = 40;
   localparam int LATENCY    = 33;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PHI_W-1:0]  phi_type;

   typedef enum logic [1:0] {
      CSR_SCALE_ENABLE     = 2'd0,
      CSR_ZERO_GUARD       = 2'd1,
      CSR_LIMITER_STRENGTH = 2'd2
   } csr_addr_type;

   // Channel order: mean magnitude, east third order, west third order,
   // east fifth order, west fifth order.
   localparam logic [3:0] CDIV_DIVISOR [CDIV_CH] = '{4'd5, 4'd3, 4'd3, 4'd15, 4'd15};

   localparam logic [NUM_W-1:0] QUO_OFFSET = NUM_W'(64'd1 << BIAS_SH);
   localparam logic [NUM_W-1:0] BIAS3      = NUM_W'(64'd3 << BIAS_SH);
   localparam logic [NUM_W-1:0] BIAS15     = NUM_W'(64'd15 << BIAS_SH);
   localparam logic [FRAC_W:0]  PHI_ONE    = (FRAC_W+1)'(64'd1 << FRAC_W);

   typedef struct packed {
      logic     neg;
      logic     bzero;
      data_type c;
      data_type d1w;
      data_type d1e;
      data_type p3w;
      data_type p3e;
   } phi_side_type;

   function automatic data_type sat_data(input logic signed [CALC_W-1:0] x);
      logic signed [CALC_W-1:0] hi;
      logic signed [CALC_W-1:0] lo;
      hi = CALC_W'((64'sd1 <<< (DATA_W-1)) - 64'sd1);
      lo = -hi - CALC_W'(1);
      if (x > hi) begin
         return hi[DATA_W-1:0];
      end else if (x < lo) begin
         return lo[DATA_W-1:0];
      end
      return x[DATA_W-1:0];
   endfunction

   // Eight steps of long division by a small constant.
   function automatic logic [CHUNK_W+3:0] cdiv_chunk(input logic [3:0] rem_in,
                                                     input logic [CHUNK_W-1:0] bits,
                                                     input logic [3:0] divisor);
      logic [4:0]         r;
      logic [CHUNK_W-1:0] q;
      r = {1'b0, rem_in};
      q = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         r = {r[3:0], bits[i]};
         if (r >= {1'b0, divisor}) begin
            q[i] = 1'b1;
            r    = r - {1'b0, divisor};
         end
      end
      return {r[3:0], q};
   endfunction

   // x * phi with the magnitude rounded to nearest, ties away from zero.
   function automatic logic signed [DATA_W+2:0] mul_phi(input data_type x, input phi_type phi);
      logic [DATA_W-1:0] ux;
      logic [PHI_W-1:0]  pn;
      logic [FRAC_W:0]   up;
      logic [DATA_W:0]   hi;
      logic [DATA_W:0]   lo;
      logic [DATA_W+1:0] m;
      ux = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
      pn = phi[PHI_W-1] ? PHI_W'(-phi) : PHI_W'(phi);
      up = pn[FRAC_W:0];
      hi = ux[DATA_W-1:FRAC_W] * up;
      lo = ux[FRAC_W-1:0] * up + (DATA_W+1)'(64'd1 << (FRAC_W-1));
      m  = {1'b0, hi} + (DATA_W+2)'(lo[DATA_W:FRAC_W]);
      if (x[DATA_W-1] != phi[PHI_W-1]) begin
         return -signed'({1'b0, m});
      end
      return signed'({1'b0, m});
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/limited_fifth_order_face_reconstruct_top.sv
// Channel      Ports                                   Handshake
// request      start, busy, req_cell_*                 taken when start and not busy
// response     rsp_valid, rsp_west_face, rsp_east_face one-cycle strobe, no back-pressure
// config       psel, penable, pwrite, paddr, pwdata    APB write in the access phase
//
// A transaction can be taken on every cycle; busy is always low.
// Each result passes through the 48-bit constant division (six chunks) and the
// 17-step restoring divider that forms phi.
// Reset is synchronous; it clears the valid bits and loads the configuration registers with their defaults only.
// No stage ever stalls, since the receiver cannot hold results off.
`default_nettype none

module limited_fifth_order_face_reconstruct_top
   import lfofr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire data_type req_cell_west2,
   input  wire data_type req_cell_west1,
   input  wire data_type req_cell_centre,
   input  wire data_type req_cell_east1,
   input  wire data_type req_cell_east2,
   output logic          rsp_valid,
   output data_type      rsp_west_face,
   output data_type      rsp_east_face,
   input  wire logic     psel,
   input  wire logic     penable,
   input  wire logic     pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   // Configuration registers.
   logic          scale_enable_ff;
   logic [15:0]   zero_guard_ff;
   logic [16:0]   limiter_strength_ff;

   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_enable_ff     <= 1'b0;
         zero_guard_ff       <= 16'd1;
         limiter_strength_ff <= PHI_ONE;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_addr_type'(paddr[3:2]))
            CSR_SCALE_ENABLE:     scale_enable_ff     <= pwdata[0];
            CSR_ZERO_GUARD:       zero_guard_ff       <= pwdata[15:0];
            CSR_LIMITER_STRENGTH: limiter_strength_ff <= pwdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_addr_type'(paddr[3:2]))
         CSR_SCALE_ENABLE:     prdata = {31'd0, scale_enable_ff};
         CSR_ZERO_GUARD:       prdata = {16'd0, zero_guard_ff};
         CSR_LIMITER_STRENGTH: prdata = {15'd0, limiter_strength_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // Input register.
   logic     s0_vld_ff;
   data_type s0_w2_ff, s0_w1_ff, s0_c_ff, s0_e1_ff, s0_e2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      s0_w2_ff <= req_cell_west2;
      s0_w1_ff <= req_cell_west1;
      s0_c_ff  <= req_cell_centre;
      s0_e1_ff <= req_cell_east1;
      s0_e2_ff <= req_cell_east2;
   end

   // Numerators for the constant dividers. The signed numerators are biased up
   // so that an unsigned long division gives the floored quotient.
   logic                     cd_vld_ff [CDIV_STEPS+1];
   logic [NUM_W-1:0]         cd_num_ff [CDIV_STEPS+1][CDIV_CH];
   logic [3:0]               cd_rem_ff [CDIV_STEPS+1][CDIV_CH];
   logic [NUM_W-1:0]         cd_quo_ff [CDIV_STEPS+1][CDIV_CH];
   data_type                 cd_c_ff   [CDIV_STEPS+1];
   logic signed [DATA_W:0]   cd_a_ff   [CDIV_STEPS+1];
   logic signed [DATA_W:0]   cd_emc_ff [CDIV_STEPS+1];

   logic signed [CALC_W-1:0] w2x, w1x, cx, e1x, e2x;
   logic signed [CALC_W-1:0] n2e, n2w, n3e, n3w;
   logic [DATA_W-1:0]        mw2, mw1, mc, me1, me2;
   logic [NUM_W-1:0]         cd_num0_in [CDIV_CH];

   always_comb begin
      w2x = CALC_W'(s0_w2_ff);
      w1x = CALC_W'(s0_w1_ff);
      cx  = CALC_W'(s0_c_ff);
      e1x = CALC_W'(s0_e1_ff);
      e2x = CALC_W'(s0_e2_ff);
      n2e = -w1x + 5 * cx + 2 * e1x + CALC_W'(3);
      n2w = 2 * w1x + 5 * cx - e1x + CALC_W'(3);
      n3e = 2 * w2x - 13 * w1x + 47 * cx + 27 * e1x - 3 * e2x + CALC_W'(30);
      n3w = -3 * w2x + 27 * w1x + 47 * cx - 13 * e1x + 2 * e2x + CALC_W'(30);
      mw2 = s0_w2_ff[DATA_W-1] ? DATA_W'(-s0_w2_ff) : DATA_W'(s0_w2_ff);
      mw1 = s0_w1_ff[DATA_W-1] ? DATA_W'(-s0_w1_ff) : DATA_W'(s0_w1_ff);
      mc  = s0_c_ff[DATA_W-1]  ? DATA_W'(-s0_c_ff)  : DATA_W'(s0_c_ff);
      me1 = s0_e1_ff[DATA_W-1] ? DATA_W'(-s0_e1_ff) : DATA_W'(s0_e1_ff);
      me2 = s0_e2_ff[DATA_W-1] ? DATA_W'(-s0_e2_ff) : DATA_W'(s0_e2_ff);
      cd_num0_in[0] = NUM_W'(mw2) + NUM_W'(mw1) + NUM_W'(mc) + NUM_W'(me1) + NUM_W'(me2);
      cd_num0_in[1] = NUM_W'(n2e >>> 1) + BIAS3;
      cd_num0_in[2] = NUM_W'(n2w >>> 1) + BIAS3;
      cd_num0_in[3] = NUM_W'(n3e >>> 2) + BIAS15;
      cd_num0_in[4] = NUM_W'(n3w >>> 2) + BIAS15;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_vld_ff[0] <= 1'b0;
      end else begin
         cd_vld_ff[0] <= s0_vld_ff;
      end
      for (int ch = 0; ch < CDIV_CH; ch++) begin
         cd_num_ff[0][ch] <= cd_num0_in[ch];
         cd_rem_ff[0][ch] <= 4'd0;
         cd_quo_ff[0][ch] <= '0;
      end
      cd_c_ff[0]   <= s0_c_ff;
      cd_a_ff[0]   <= (DATA_W+1)'(s0_c_ff) - (DATA_W+1)'(s0_w1_ff);
      cd_emc_ff[0] <= (DATA_W+1)'(s0_e1_ff) - (DATA_W+1)'(s0_c_ff);
   end

   for (genvar j = 1; j <= CDIV_STEPS; j++) begin : g_cdiv
      logic [CHUNK_W+3:0] step_res [CDIV_CH];

      for (genvar ch = 0; ch < CDIV_CH; ch++) begin : g_ch
         assign step_res[ch] = cdiv_chunk(cd_rem_ff[j-1][ch],
                                          cd_num_ff[j-1][ch][NUM_W-1 -: CHUNK_W],
                                          CDIV_DIVISOR[ch]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_vld_ff[j] <= 1'b0;
         end else begin
            cd_vld_ff[j] <= cd_vld_ff[j-1];
         end
         for (int ch = 0; ch < CDIV_CH; ch++) begin
            cd_num_ff[j][ch] <= cd_num_ff[j-1][ch] << CHUNK_W;
            cd_rem_ff[j][ch] <= step_res[ch][CHUNK_W+3:CHUNK_W];
            cd_quo_ff[j][ch] <= {cd_quo_ff[j-1][ch][NUM_W-CHUNK_W-1:0],
                                 step_res[ch][CHUNK_W-1:0]};
         end
         cd_c_ff[j]   <= cd_c_ff[j-1];
         cd_a_ff[j]   <= cd_a_ff[j-1];
         cd_emc_ff[j] <= cd_emc_ff[j-1];
      end
   end

   // Guard product and the first blend differences.
   logic                   g_vld_ff;
   logic [NUM_W-1:0]       g_prod_ff;
   data_type               g_c_ff, g_d1w_ff, g_d1e_ff, g_p3w_ff, g_p3e_ff;
   logic signed [DATA_W:0] g_a_ff, g_emc_ff;

   logic [DATA_W-1:0]      mean_in;
   logic [NUM_W-1:0]       q2e, q2w, q3e, q3w;
   data_type               p2e_in, p2w_in, p3e_in, p3w_in;
   data_type               cd_c_last;

   always_comb begin
      cd_c_last = cd_c_ff[CDIV_STEPS];
      mean_in   = cd_quo_ff[CDIV_STEPS][0][DATA_W-1:0];
      if (mean_in == '0) begin
         mean_in = DATA_W'(PHI_ONE);
      end
      q2e    = cd_quo_ff[CDIV_STEPS][1] - QUO_OFFSET;
      q2w    = cd_quo_ff[CDIV_STEPS][2] - QUO_OFFSET;
      q3e    = cd_quo_ff[CDIV_STEPS][3] - QUO_OFFSET;
      q3w    = cd_quo_ff[CDIV_STEPS][4] - QUO_OFFSET;
      p2e_in = sat_data(signed'(q2e[CALC_W-1:0]));
      p2w_in = sat_data(signed'(q2w[CALC_W-1:0]));
      p3e_in = sat_data(signed'(q3e[CALC_W-1:0]));
      p3w_in = sat_data(signed'(q3w[CALC_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= cd_vld_ff[CDIV_STEPS];
      end
      g_prod_ff <= NUM_W'(zero_guard_ff) * NUM_W'(mean_in);
      g_c_ff    <= cd_c_last;
      g_d1w_ff  <= sat_data(CALC_W'(cd_c_last) - CALC_W'(p2w_in));
      g_d1e_ff  <= sat_data(CALC_W'(cd_c_last) - CALC_W'(p2e_in));
      g_p3w_ff  <= p3w_in;
      g_p3e_ff  <= p3e_in;
      g_a_ff    <= cd_a_ff[CDIV_STEPS];
      g_emc_ff  <= cd_emc_ff[CDIV_STEPS];
   end

   // Limiter operands: magnitudes shifted together into 31 bits.
   logic                     h_vld_ff;
   logic [30:0]              h_ua_ff, h_ub_ff;
   phi_side_type             h_side_ff;

   logic [NUM_W-1:0]         gsum;
   logic [DATA_W-1:0]        guard;
   logic signed [DATA_W+2:0] b_full;
   logic [DATA_W+1:0]        ua, ub, uor;
   logic [1:0]               sh;

   always_comb begin
      gsum   = g_prod_ff + NUM_W'(64'd1 << (FRAC_W-1));
      guard  = scale_enable_ff ? gsum[FRAC_W+DATA_W-1:FRAC_W] : DATA_W'(zero_guard_ff);
      b_full = (DATA_W+3)'(g_emc_ff) + signed'({3'b000, guard});
      ua     = (DATA_W+2)'(g_a_ff[DATA_W] ? -g_a_ff : g_a_ff);
      ub     = (DATA_W+2)'(b_full[DATA_W+2] ? -b_full : b_full);
      uor    = ua | ub;
      if (uor[DATA_W+1]) begin
         sh = 2'd3;
      end else if (uor[DATA_W]) begin
         sh = 2'd2;
      end else if (uor[DATA_W-1]) begin
         sh = 2'd1;
      end else begin
         sh = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
      h_ua_ff         <= 31'(ua >> sh);
      h_ub_ff         <= 31'(ub >> sh);
      h_side_ff.neg   <= g_a_ff[DATA_W] != b_full[DATA_W+2];
      h_side_ff.bzero <= b_full == '0;
      h_side_ff.c     <= g_c_ff;
      h_side_ff.d1w   <= g_d1w_ff;
      h_side_ff.d1e   <= g_d1e_ff;
      h_side_ff.p3w   <= g_p3w_ff;
      h_side_ff.p3e   <= g_p3e_ff;
   end

   // Squares and cross product.
   logic         m_vld_ff;
   logic [63:0]  m_num_ff, m_den_ff;
   phi_side_type m_side_ff;

   logic [61:0]  sq_a, sq_b, cross_ab;

   always_comb begin
      sq_a     = h_ua_ff * h_ua_ff;
      sq_b     = h_ub_ff * h_ub_ff;
      cross_ab = h_ua_ff * h_ub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= h_vld_ff;
      end
      m_den_ff  <= 64'(sq_a) + 64'(sq_b);
      m_num_ff  <= {1'b0, cross_ab, 1'b0};
      m_side_ff <= h_side_ff;
   end

   logic            dv_vld;
   logic [FRAC_W:0] dv_quo;
   phi_side_type    dv_side;

   lfofr_phi_div u_phi_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_vld_ff),
      .in_num    (m_num_ff),
      .in_den    (m_den_ff),
      .in_side   (m_side_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Signed phi with the floor applied.
   logic         f_vld_ff;
   phi_type      f_phi_ff;
   phi_side_type f_side_ff;

   phi_type phi_raw, phi_floor, phi_in;

   always_comb begin
      phi_raw   = dv_side.neg ? -signed'({1'b0, dv_quo}) : signed'({1'b0, dv_quo});
      phi_floor = signed'({1'b0, PHI_ONE}) - signed'({1'b0, limiter_strength_ff});
      if (dv_side.bzero || phi_raw <= phi_floor) begin
         phi_in = phi_floor;
      end else begin
         phi_in = phi_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= dv_vld;
      end
      f_phi_ff  <= phi_in;
      f_side_ff <= dv_side;
   end

   // First blend product.
   logic                     b2_vld_ff;
   logic signed [DATA_W+2:0] b2_m1w_ff, b2_m1e_ff;
   phi_type                  b2_phi_ff;
   data_type                 b2_c_ff, b2_p3w_ff, b2_p3e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_vld_ff <= 1'b0;
      end else begin
         b2_vld_ff <= f_vld_ff;
      end
      b2_m1w_ff <= mul_phi(f_side_ff.d1w, f_phi_ff);
      b2_m1e_ff <= mul_phi(f_side_ff.d1e, f_phi_ff);
      b2_phi_ff <= f_phi_ff;
      b2_c_ff   <= f_side_ff.c;
      b2_p3w_ff <= f_side_ff.p3w;
      b2_p3e_ff <= f_side_ff.p3e;
   end

   // Third-order blend and the difference to the fifth-order value.
   logic     b3_vld_ff;
   data_type b3_loww_ff, b3_lowe_ff, b3_d2w_ff, b3_d2e_ff;
   phi_type  b3_phi_ff;
   data_type low_w_in, low_e_in;

   always_comb begin
      low_w_in = sat_data(CALC_W'(b2_c_ff) - CALC_W'(b2_m1w_ff));
      low_e_in = sat_data(CALC_W'(b2_c_ff) - CALC_W'(b2_m1e_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_vld_ff <= 1'b0;
      end else begin
         b3_vld_ff <= b2_vld_ff;
      end
      b3_loww_ff <= low_w_in;
      b3_lowe_ff <= low_e_in;
      b3_d2w_ff  <= sat_data(CALC_W'(low_w_in) - CALC_W'(b2_p3w_ff));
      b3_d2e_ff  <= sat_data(CALC_W'(low_e_in) - CALC_W'(b2_p3e_ff));
      b3_phi_ff  <= b2_phi_ff;
   end

   // Second blend product.
   logic                     b4_vld_ff;
   data_type                 b4_loww_ff, b4_lowe_ff;
   logic signed [DATA_W+2:0] b4_m2w_ff, b4_m2e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_vld_ff <= 1'b0;
      end else begin
         b4_vld_ff <= b3_vld_ff;
      end
      b4_loww_ff <= b3_loww_ff;
      b4_lowe_ff <= b3_lowe_ff;
      b4_m2w_ff  <= mul_phi(b3_d2w_ff, b3_phi_ff);
      b4_m2e_ff  <= mul_phi(b3_d2e_ff, b3_phi_ff);
   end

   // Output register.
   logic     rsp_valid_ff;
   data_type rsp_west_ff, rsp_east_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b4_vld_ff;
      end
      rsp_west_ff <= sat_data(CALC_W'(b4_loww_ff) - CALC_W'(b4_m2w_ff));
      rsp_east_ff <= sat_data(CALC_W'(b4_lowe_ff) - CALC_W'(b4_m2e_ff));
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_west_face = rsp_west_ff;
   assign rsp_east_face = rsp_east_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transaction did not emerge after the pipeline latency");

   a_mean_width: assert property (@(posedge clock) disable iff (reset)
      cd_vld_ff[CDIV_STEPS] |-> cd_quo_ff[CDIV_STEPS][0][NUM_W-1:DATA_W] == '0)
      else $error("mean magnitude exceeds the data width");

   a_phi_range: assert property (@(posedge clock) disable iff (reset)
      f_vld_ff |-> (f_phi_ff <= signed'({1'b0, PHI_ONE})
                    && f_phi_ff >= -signed'({1'b0, PHI_ONE})))
      else $error("phi magnitude above one");

endmodule

`default_nettype wire

>>> rtl/core/lfofr_phi_div.sv
`default_nettype none

module lfofr_phi_div
   import lfofr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [63:0]  in_num,
   input  wire logic [63:0]  in_den,
   input  wire phi_side_type in_side,
   output logic              out_valid,
   output logic [FRAC_W:0]   out_quo,
   output phi_side_type      out_side
);

   logic               vld_ff  [DIV_STEPS];
   logic [63:0]        rem_ff  [DIV_STEPS];
   logic [63:0]        den_ff  [DIV_STEPS];
   logic [FRAC_W:0]    quo_ff  [DIV_STEPS];
   phi_side_type       side_ff [DIV_STEPS];

   logic               first_ge_in;
   logic [63:0]        first_rem_in;

   // The numerator never exceeds the denominator, so the first step gives
   // the integer bit alone.
   always_comb begin
      first_ge_in  = (in_den != 64'd0) && (in_num >= in_den);
      first_rem_in = first_ge_in ? in_num - in_den : in_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= first_rem_in;
      den_ff[0]  <= in_den;
      quo_ff[0]  <= (FRAC_W+1)'(first_ge_in);
      side_ff[0] <= in_side;
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
      logic [63:0] shifted_in;
      logic        ge_in;
      assign shifted_in = {rem_ff[k-1][62:0], 1'b0};
      assign ge_in      = (den_ff[k-1] != 64'd0) && (shifted_in >= den_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rem_ff[k]  <= ge_in ? shifted_in - den_ff[k-1] : shifted_in;
         den_ff[k]  <= den_ff[k-1];
         quo_ff[k]  <= {quo_ff[k-1][FRAC_W-1:0], ge_in};
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quo   = quo_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##DIV_STEPS out_valid)
      else $error("phi divider lost a transaction");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_quo <= PHI_ONE)
      else $error("phi quotient above one");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_ff[DIV_STEPS-1] < den_ff[DIV_STEPS-1] || den_ff[DIV_STEPS-1] == 64'd0))
      else $error("phi divider remainder not reduced");

endmodule

`default_nettype wire

>>> sim/limited_fifth_order_face_reconstruct_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module limited_fifth_order_face_reconstruct_top_tb;
   import lfofr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   data_type    req_cell_west2 = '0;
   data_type    req_cell_west1 = '0;
   data_type    req_cell_centre = '0;
   data_type    req_cell_east1 = '0;
   data_type    req_cell_east2 = '0;
   logic        rsp_valid;
   data_type    rsp_west_face;
   data_type    rsp_east_face;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   limited_fifth_order_face_reconstruct_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cell_west2(req_cell_west2), .req_cell_west1(req_cell_west1),
      .req_cell_centre(req_cell_centre), .req_cell_east1(req_cell_east1),
      .req_cell_east2(req_cell_east2), .rsp_valid(rsp_valid),
      .rsp_west_face(rsp_west_face), .rsp_east_face(rsp_east_face),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   typedef struct {
      data_type west;
      data_type east;
   } faces_type;

   // Model copy of the registers.
   logic        scale_on;
   logic [15:0] guard_eps;
   logic [16:0] strength;

   faces_type   face_queue[$];
   int          mismatches = 0;
   int          faces_checked = 0;
   int          stencils_sent = 0;
   int          idle_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint fdiv(input longint x, input longint d);
      longint q;
      q = x / d;
      if ((x % d != 0) && x < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint absval(input longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic longint scale_by_phi(input longint x, input longint phi);
      longint unsigned ux, up, m;
      ux = absval(x);
      up = absval(phi);
      m = (ux >> 16) * up + (((ux & 64'hFFFF) * up + 64'd32768) >> 16);
      return ((x < 0) != (phi < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint limiter_phi(input longint a, input longint b);
      longint floor_val, phi;
      longint unsigned ua, ub, num, den, rem, q;
      floor_val = 64'sd65536 - longint'(strength);
      if (b == 0) return floor_val;
      ua = absval(a);
      ub = absval(b);
      while (((ua | ub) >> 31) != 0) begin
         ua = ua >> 1;
         ub = ub >> 1;
      end
      den = ua * ua + ub * ub;
      num = 2 * ua * ub;
      q = 0;
      rem = num;
      if (den != 0 && rem >= den) begin
         q = 1;
         rem = rem - den;
      end
      for (int i = 0; i < 16 && den != 0; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            q = q | 1;
            rem = rem - den;
         end
      end
      phi = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
      return phi > floor_val ? phi : floor_val;
   endfunction

   function automatic longint blend(input longint c, input longint p3, input longint p5,
                                    input longint phi);
      longint low;
      low = sat32(c - scale_by_phi(sat32(c - p3), phi));
      return sat32(low - scale_by_phi(sat32(low - p5), phi));
   endfunction

   function automatic faces_type predict_faces(input data_type w2, input data_type w1,
                                               input data_type c, input data_type e1,
                                               input data_type e2);
      longint lw2, lw1, lc, le1, le2, guard, phi;
      longint unsigned s;
      faces_type f;
      lw2 = w2; lw1 = w1; lc = c; le1 = e1; le2 = e2;
      if (scale_on) begin
         s = (absval(lw2) + absval(lw1) + absval(lc) + absval(le1) + absval(le2)) / 5;
         if (s == 0) s = 65536;
         guard = longint'((longint'(guard_eps) * s + 32768) >> 16);
      end else begin
         guard = guard_eps;
      end
      phi = limiter_phi(lc - lw1, le1 - lc + guard);
      f.west = data_type'(blend(lc,
         sat32(fdiv(2 * lw1 + 5 * lc - le1 + 3, 6)),
         sat32(fdiv(-3 * lw2 + 27 * lw1 + 47 * lc - 13 * le1 + 2 * le2 + 30, 60)), phi));
      f.east = data_type'(blend(lc,
         sat32(fdiv(-lw1 + 5 * lc + 2 * le1 + 3, 6)),
         sat32(fdiv(2 * lw2 - 13 * lw1 + 47 * lc + 27 * le1 - 3 * le2 + 30, 60)), phi));
      return f;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      faces_type exp_f;
      if (!reset && rsp_valid) begin
         if (face_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transaction");
         end else begin
            exp_f = face_queue.pop_front();
            faces_checked++;
            if (rsp_west_face !== exp_f.west || rsp_east_face !== exp_f.east) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: west exp %h got %h, east exp %h got %h",
                           exp_f.west, rsp_west_face, exp_f.east, rsp_east_face);
            end
         end
      end
   end

   task automatic send_stencil(input data_type w2, input data_type w1, input data_type c,
                               input data_type e1, input data_type e2);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_cell_west2 <= w2;
      req_cell_west1 <= w1;
      req_cell_centre <= c;
      req_cell_east1 <= e1;
      req_cell_east2 <= e2;
      @(posedge clock);
      while (busy) @(posedge clock);
      face_queue.push_back(predict_faces(w2, w1, c, e1, e2));
      stencils_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (face_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic csr_write(input csr_addr_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_SCALE_ENABLE:     scale_on = value[0];
         CSR_ZERO_GUARD:       guard_eps = value[15:0];
         CSR_LIMITER_STRENGTH: strength = value[16:0];
         default: ;
      endcase
   endtask

   function automatic data_type rand_cell;
      case ($urandom_range(5))
         0: return data_type'($urandom);
         1: return data_type'($urandom_range(3) == 0 ? 32'h7FFFFFFF : 32'h80000000);
         2: return data_type'($signed($urandom_range(8191)) - 4096);
         default: return data_type'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   task automatic send_random(input int count);
      data_type c, w1, e1;
      for (int i = 0; i < count; i++) begin
         c = rand_cell();
         w1 = rand_cell();
         e1 = rand_cell();
         // Sometimes make the limiter denominator vanish or the stencil smooth.
         if ($urandom_range(9) == 0) e1 = c;
         if ($urandom_range(9) == 0) w1 = c;
         send_stencil(rand_cell(), w1, c, e1, rand_cell());
      end
   endtask

   task automatic test_directed;
      idle_pct = 0;
      send_stencil(0, 0, 0, 0, 0);
      send_stencil(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_stencil(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_stencil(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_stencil(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_stencil(0, 65536, 131072, 196608, 262144);
      send_stencil(0, 65536, 131072, 131071, 0);
      send_stencil(-5, -3, 7, 6, 2);
      send_stencil(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 32'hAAAAAAAA);
      send_stencil(32'h55555555, 0, 65536, 0, 32'h12345678);
      drain();
   endtask

   task automatic test_registers;
      // Strength above 1.0 makes the floor negative; zero strength pins phi to one.
      csr_write(CSR_LIMITER_STRENGTH, 32'h0001FFFF);
      csr_write(CSR_ZERO_GUARD, 32'hFFFF0000);
      send_random(12);
      drain();
      csr_write(CSR_LIMITER_STRENGTH, 0);
      csr_write(CSR_ZERO_GUARD, 32'hFFFF);
      csr_write(CSR_SCALE_ENABLE, 32'hFFFFFFFF);
      send_stencil(0, 0, 0, 0, 0);
      send_stencil(1, 2, 3, 3, 5);
      send_random(10);
      drain();
      csr_write(CSR_LIMITER_STRENGTH, 32'd32768);
      csr_write(CSR_ZERO_GUARD, 0);
      send_stencil(0, 0, 0, 0, 0);
      send_random(10);
      drain();
   endtask

   task automatic test_random_phases;
      int pcts[4] = '{0, 87, 38, 0};
      for (int p = 0; p < 8; p++) begin
         idle_pct = pcts[p % 4];
         csr_write(CSR_SCALE_ENABLE, $urandom_range(1));
         csr_write(CSR_ZERO_GUARD, $urandom_range(2) == 0 ? 0 : $urandom_range(65535));
         csr_write(CSR_LIMITER_STRENGTH, $urandom_range(3) == 0 ? 65536 :
                   $urandom_range(131071));
         send_random(126);
         drain();
      end
   endtask

   initial begin
      scale_on = 1'b0;
      guard_eps = 16'd1;
      strength = 17'd65536;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_registers();
      test_random_phases();
      drain();
      $display("Sent %0d stencils and checked %0d face pairs over several register settings",
               stencils_sent, faces_checked);
      if (mismatches == 0 && face_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
